// ===== sv/alsp_pkg.sv =====
// Shared types and constants of the antialiased LED span painter.
package alsp_pkg;

	localparam int KIND_W     = 3;
	localparam int COLOR_W    = 8;
	localparam int POS_W      = 21;
	localparam int PIX_IDX_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR_ALL = 3'd0,
		KIND_CLEAR_ONE = 3'd1,
		KIND_ADD_INDEX = 3'd2,
		KIND_POINT     = 3'd3,
		KIND_SPAN      = 3'd4,
		KIND_RECT      = 3'd5,
		KIND_PIX2D     = 3'd6,
		KIND_SHOW      = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SHOW_RD,
		ST_SHOW_LD,
		ST_SPAN,
		ST_ROW,
		ST_ROWC,
		ST_POINT2,
		ST_PLACE,
		ST_READ,
		ST_WRITE
	} state_t;

	typedef enum logic [1:0] {
		SP_FIRST,
		SP_MID,
		SP_END
	} span_ph_t;

	// status of the index placement unit
	typedef struct packed {
		logic done;
		logic hit;
	} place_st_t;

endpackage

// ===== sv/alsp_ifs.sv =====
// Command and pixel channel interfaces of the span painter.
interface alsp_cmd_if;
	import alsp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic [COLOR_W-1:0]        in_red;
	logic [COLOR_W-1:0]        in_green;
	logic [COLOR_W-1:0]        in_blue;
	logic signed [POS_W-1:0]   first_pos;
	logic signed [POS_W-1:0]   second_pos;
	logic signed [POS_W-1:0]   third_pos;
	logic signed [POS_W-1:0]   fourth_pos;

	modport source (output valid, kind, in_red, in_green, in_blue,
		first_pos, second_pos, third_pos, fourth_pos, input ready);
	modport sink (input valid, kind, in_red, in_green, in_blue,
		first_pos, second_pos, third_pos, fourth_pos, output ready);
endinterface

interface alsp_pix_if;
	import alsp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PIX_IDX_W-1:0]  pixel_index;
	logic [COLOR_W-1:0]    out_red;
	logic [COLOR_W-1:0]    out_green;
	logic [COLOR_W-1:0]    out_blue;
	logic                  last;

	modport source (output valid, pixel_index, out_red, out_green, out_blue, last,
		input ready);
	modport sink (input valid, pixel_index, out_red, out_green, out_blue, last,
		output ready);
endinterface

// ===== sv/alsp_ram.sv =====
// Generic simple dual-port RAM with registered read.
module alsp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/alsp_place.sv =====
// Index placement unit: maps a signed LED index onto a slot by the strip rule.
module alsp_place #(
	parameter int IW = 16,
	parameter int NW = 7,
	parameter int AW = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [IW-1:0]   idx,
	input  logic [NW-1:0]          n,
	input  logic                   ring,
	output alsp_pkg::place_st_t    st,
	output logic [AW-1:0]          slot
);
	import alsp_pkg::*;

	localparam int CNW = $clog2(IW + 1);

	logic            busy_q;
	logic            done_q;
	logic            hit_q;
	logic            neg_q;
	logic [IW-1:0]   mag_q;
	logic [NW-1:0]   rem_q;
	logic [CNW-1:0]  cnt_q;
	logic [AW-1:0]   slot_q;

	logic [NW:0]     trial;
	logic [NW:0]     trial_sub;
	logic [NW-1:0]   rem_nx;
	logic [NW-1:0]   wrap_diff;
	logic            in_range;

	// one restoring remainder step per cycle, magnitude MSB first
	always_comb begin
		trial     = {rem_q, mag_q[IW-1]};
		trial_sub = (trial >= {1'b0, n}) ? (trial - {1'b0, n}) : trial;
		rem_nx    = trial_sub[NW-1:0];
		wrap_diff = n - rem_nx;
		in_range  = !idx[IW-1] && (idx < $signed(IW'(n)));
	end

	// control: run a remainder pass in ring mode, answer at once otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= ring;
				done_q <= !ring;
			end else if (busy_q && cnt_q == CNW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= idx[IW-1];
			mag_q  <= idx[IW-1] ? ((~idx) + IW'(1)) : idx;
			rem_q  <= '0;
			cnt_q  <= CNW'(IW);
			hit_q  <= ring ? 1'b1 : in_range;
			slot_q <= idx[AW-1:0];
		end else if (busy_q) begin
			rem_q <= rem_nx;
			mag_q <= mag_q << 1;
			cnt_q <= cnt_q - CNW'(1);
			if (cnt_q == CNW'(1)) begin
				slot_q <= (neg_q && rem_nx != '0) ? wrap_diff[AW-1:0] : rem_nx[AW-1:0];
			end
		end
	end

	assign st   = '{done: done_q, hit: hit_q};
	assign slot = slot_q;
endmodule

// ===== sv/antialiased_led_span_painter_core.sv =====
// Top level of the antialiased LED span painter.
//
// Commands arrive on the cmd channel (valid/ready); one beat is one command.
// Shown LEDs leave on the pix channel, one beat per LED, last set on LED n-1.
// The configuration port (cfg_we, cfg_index, cfg_data) writes led_count,
// ring_mode, row_width and row_count; write it only while the block is idle.
// The frame buffer lives in one RAM with registered read; each LED update
// places the index, then reads, then does a saturating write back (a zero
// write for clear one), so no two updates overlap. In ring mode the placing
// runs the bit-serial remainder unit over the IW index bits, where IW is the
// index width (15 at eight fraction bits). A span or rect does one update per
// covered LED; clear all writes LEDs 0 to n-1. Show reads and loads each LED
// in turn; a stalled LED holds in the output register and the next read
// waits for it.
// cmd ready is high only between commands; after the last LED of a show is
// loaded the block takes the next command while that beat still waits.
// Reset empties the frame buffer by a clearing pass over all MAX_LEDS slots and
// sets led_count 64, ring_mode 0, row_width 8, row_count 8.
module antialiased_led_span_painter_core #(
	parameter int MAX_LEDS      = 64,
	parameter int POS_FRAC_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	alsp_cmd_if.sink                        cmd,
	alsp_pix_if.source                      pix,
	input  logic                            cfg_we,
	input  logic [alsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [alsp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import alsp_pkg::*;

	localparam int F    = POS_FRAC_BITS;
	localparam int ONE  = 1 << F;
	localparam int AW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int NW   = $clog2(MAX_LEDS + 1);
	localparam int IW   = (22 - F > 15) ? (22 - F) : 15;
	localparam int PW   = IW + F;
	localparam int CW   = F + 1;
	localparam int BW   = 14;
	localparam int FBW  = 3 * COLOR_W;

	typedef logic [COLOR_W-1:0] col_t;

	// scale one channel by a coverage, truncating
	function automatic col_t scale8(input col_t c, input logic [CW-1:0] f);
		logic [CW+COLOR_W-1:0] p;
		p = c * f;
		return p[F+COLOR_W-1:F];
	endfunction

	function automatic col_t sat8(input col_t a, input col_t b);
		logic [COLOR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COLOR_W] ? '1 : s[COLOR_W-1:0];
	endfunction

	function automatic logic signed [PW-1:0] clamp_pos(input logic signed [PW-1:0] v,
			input logic signed [PW-1:0] hi);
		if (v < 0) return '0;
		else if (v > hi) return hi;
		else return v;
	endfunction

	function automatic logic [CW-1:0] clamp_cov(input logic signed [PW:0] d);
		if (d < 0) return '0;
		else if (d > $signed((PW+1)'(ONE))) return CW'(ONE);
		else return d[CW-1:0];
	endfunction

	// configuration registers
	logic [CFG_DATA_W-1:0] led_count_q;
	logic                  ring_q;
	logic [CFG_DATA_W-1:0] row_width_q;
	logic [CFG_DATA_W-1:0] row_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= 7'd64;
			ring_q      <= 1'b0;
			row_width_q <= 7'd8;
			row_count_q <= 7'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LED_COUNT: led_count_q <= cfg_data;
				CFG_RING_MODE: ring_q      <= cfg_data[0];
				CFG_ROW_WIDTH: row_width_q <= cfg_data;
				CFG_ROW_COUNT: row_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped register views
	logic [NW-1:0]         n_eff;
	logic [AW-1:0]         n_last;
	logic [NW-1:0]         n_m1;
	logic [CFG_DATA_W-1:0] w_eff;
	logic [CFG_DATA_W-1:0] h_eff;

	always_comb begin
		if (led_count_q == '0) n_eff = NW'(1);
		else if (led_count_q > MAX_LEDS) n_eff = NW'(MAX_LEDS);
		else n_eff = NW'(led_count_q);
		n_m1   = n_eff - NW'(1);
		n_last = n_m1[AW-1:0];
		if (row_width_q == '0) w_eff = 7'd1;
		else if (row_width_q > 7'd64) w_eff = 7'd64;
		else w_eff = row_width_q;
		if (row_count_q == '0) h_eff = 7'd1;
		else if (row_count_q > 7'd64) h_eff = 7'd64;
		else h_eff = row_count_q;
	end

	// state and working registers
	state_t                 state_q, state_d;
	state_t                 ret_q;
	span_ph_t               sp_q, sp_d;
	kind_t                  kind_q;
	col_t                   col_r_q, col_g_q, col_b_q;
	logic signed [PW-1:0]   pa_q, pb_q, ya_q, yb_q;
	logic signed [PW-1:0]   span_x_q, span_e_q;
	col_t                   span_r_q, span_g_q, span_b_q;
	logic signed [IW-1:0]   k_q, k_d;
	logic                   row_first_q;
	logic                   rlast_q, rlast_d;
	logic [CW-1:0]          row_cov_q, row_cov_d;
	logic [7:0]             rk_q;
	logic [BW-1:0]          base_q;
	logic [AW:0]            cnt_q;
	logic [CW-1:0]          op_cov_q;
	logic                   op_clr_q;
	col_t                   op_r_q, op_g_q, op_b_q;
	col_t                   sc_r_q, sc_g_q, sc_b_q;
	logic                   pix_v_q;
	logic [PIX_IDX_W-1:0]   pix_idx_q;
	col_t                   pix_r_q, pix_g_q, pix_b_q;
	logic                   pix_last_q;
	logic                   init_q;

	// op issue request
	logic                   iss_v;
	logic signed [IW-1:0]   iss_idx;
	logic [CW-1:0]          iss_cov;
	logic                   iss_clr;
	col_t                   iss_r, iss_g, iss_b;
	state_t                 iss_ret;

	// memory port
	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [FBW-1:0]         ram_wdata, ram_rdata;

	place_st_t              pl_st;
	logic [AW-1:0]          pl_slot;

	// input decode
	kind_t                  in_kind;
	logic signed [PW-1:0]   p0x, p1x, p2x, p3x, wq, hq;
	logic signed [IW-1:0]   fl0, fl1;
	logic [F-1:0]           fr0;
	logic                   in_grid;
	logic [BW-1:0]          grid_idx;
	logic                   pix_fire;

	always_comb begin
		in_kind  = kind_t'(cmd.kind);
		p0x      = PW'(cmd.first_pos);
		p1x      = PW'(cmd.second_pos);
		p2x      = PW'(cmd.third_pos);
		p3x      = PW'(cmd.fourth_pos);
		wq       = $signed(PW'(w_eff) << F);
		hq       = $signed(PW'(h_eff) << F);
		fl0      = IW'(cmd.first_pos >>> F);
		fl1      = IW'(cmd.second_pos >>> F);
		fr0      = cmd.first_pos[F-1:0];
		in_grid  = !fl0[IW-1] && (fl0 < $signed(IW'(w_eff)))
			&& !fl1[IW-1] && (fl1 < $signed(IW'(h_eff)));
		grid_idx = BW'(fl1[5:0] * w_eff) + BW'(fl0[6:0]);
		pix_fire = pix_v_q && pix.ready;
	end

	// span and row views
	logic signed [IW-1:0]   sx_i, se_i;
	logic [F-1:0]           sx_f, se_f;
	logic [6:0]             y0i, y1i;

	always_comb begin
		sx_i = IW'(span_x_q >>> F);
		se_i = IW'(span_e_q >>> F);
		sx_f = span_x_q[F-1:0];
		se_f = span_e_q[F-1:0];
		y0i  = ya_q[F+6:F];
		y1i  = yb_q[F+6:F];
	end

	// next state, op issue and memory port
	always_comb begin
		state_d   = state_q;
		sp_d      = sp_q;
		k_d       = k_q;
		rlast_d   = rlast_q;
		row_cov_d = row_cov_q;
		iss_v     = 1'b0;
		iss_idx   = '0;
		iss_cov   = CW'(ONE);
		iss_clr   = 1'b0;
		iss_r     = cmd.in_red;
		iss_g     = cmd.in_green;
		iss_b     = cmd.in_blue;
		iss_ret   = ST_IDLE;
		ram_we    = 1'b0;
		ram_waddr = pl_slot;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = pl_slot;
		unique case (state_q)
			ST_IDLE: begin
				if (init_q) begin
					// reset clearing pass over the whole buffer
					ram_we    = 1'b1;
					ram_waddr = cnt_q[AW-1:0];
				end else if (cmd.valid) begin
					unique case (in_kind)
						KIND_CLEAR_ALL: state_d = ST_CLEAR;
						KIND_CLEAR_ONE: begin
							iss_v   = 1'b1;
							iss_idx = fl0;
							iss_clr = 1'b1;
						end
						KIND_ADD_INDEX: begin
							iss_v   = 1'b1;
							iss_idx = fl0;
						end
						KIND_POINT: begin
							iss_v = 1'b1;
							if (fr0 != '0) begin
								iss_idx = fl0 + IW'(1);
								iss_cov = CW'(fr0);
								iss_ret = ST_POINT2;
							end else begin
								iss_idx = fl0;
							end
						end
						KIND_SPAN: state_d = ST_SPAN;
						KIND_RECT: state_d = ST_ROW;
						KIND_PIX2D: begin
							iss_v   = in_grid;
							iss_idx = IW'(grid_idx);
						end
						KIND_SHOW: state_d = ST_SHOW_RD;
						default: ;
					endcase
				end
			end
			ST_POINT2: begin
				iss_v   = 1'b1;
				iss_idx = IW'(pa_q >>> F);
				iss_cov = CW'(ONE) - CW'(pa_q[F-1:0]);
				iss_r   = col_r_q;
				iss_g   = col_g_q;
				iss_b   = col_b_q;
			end
			ST_SPAN: begin
				iss_r   = span_r_q;
				iss_g   = span_g_q;
				iss_b   = span_b_q;
				iss_ret = ST_SPAN;
				unique case (sp_q)
					SP_FIRST: begin
						iss_v   = 1'b1;
						iss_idx = sx_i;
						if (sx_i == se_i) begin
							iss_cov = clamp_cov((PW+1)'(span_e_q) - (PW+1)'(span_x_q));
							sp_d    = SP_END;
						end else begin
							iss_cov = CW'(ONE) - CW'(sx_f);
							k_d     = sx_i + IW'(1);
							sp_d    = SP_MID;
						end
					end
					SP_MID: begin
						iss_v = 1'b1;
						if (k_q < se_i) begin
							iss_idx = k_q;
							k_d     = k_q + IW'(1);
						end else begin
							iss_idx = se_i;
							iss_cov = CW'(se_f);
							sp_d    = SP_END;
						end
					end
					default: begin
						state_d = (kind_q == KIND_RECT) ? ST_ROW : ST_IDLE;
					end
				endcase
			end
			ST_ROW: begin
				if (row_first_q) begin
					state_d = ST_ROWC;
					if (y0i == y1i) begin
						row_cov_d = clamp_cov((PW+1)'(yb_q) - (PW+1)'(ya_q));
						rlast_d   = 1'b1;
					end else begin
						row_cov_d = CW'(ONE) - CW'(ya_q[F-1:0]);
						rlast_d   = 1'b0;
					end
				end else if (rlast_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_ROWC;
					if ((rk_q + 8'd1) < {1'b0, y1i}) begin
						row_cov_d = CW'(ONE);
					end else begin
						row_cov_d = CW'(yb_q[F-1:0]);
						rlast_d   = 1'b1;
					end
				end
			end
			ST_ROWC: state_d = ST_SPAN;
			ST_PLACE: begin
				if (pl_st.done) begin
					state_d = pl_st.hit ? ST_READ : ret_q;
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				ram_we = 1'b1;
				if (!op_clr_q) begin
					ram_wdata = {sat8(ram_rdata[3*COLOR_W-1:2*COLOR_W], sc_r_q),
						sat8(ram_rdata[2*COLOR_W-1:COLOR_W], sc_g_q),
						sat8(ram_rdata[COLOR_W-1:0], sc_b_q)};
				end
				state_d = ret_q;
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				if (cnt_q[AW-1:0] == n_last) state_d = ST_IDLE;
			end
			ST_SHOW_RD: begin
				if (!pix_v_q || pix.ready) begin
					ram_re    = 1'b1;
					ram_raddr = cnt_q[AW-1:0];
					state_d   = ST_SHOW_LD;
				end
			end
			ST_SHOW_LD: begin
				state_d = (cnt_q[AW-1:0] == n_last) ? ST_IDLE : ST_SHOW_RD;
			end
			default: state_d = ST_IDLE;
		endcase
		if (iss_v) state_d = ST_PLACE;
	end

	assign cmd.ready = (state_q == ST_IDLE) && !init_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			sp_q        <= SP_FIRST;
			row_first_q <= 1'b1;
			rlast_q     <= 1'b0;
			pix_v_q     <= 1'b0;
			init_q      <= 1'b1;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (iss_v) ret_q <= iss_ret;
			if (state_q == ST_SHOW_LD) pix_v_q <= 1'b1;
			else if (pix_fire) pix_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (init_q) begin
						cnt_q <= cnt_q + (AW+1)'(1);
						if (cnt_q == (AW+1)'(MAX_LEDS - 1)) begin
							init_q <= 1'b0;
							cnt_q  <= '0;
						end
					end else if (cmd.valid) begin
						cnt_q       <= '0;
						sp_q        <= SP_FIRST;
						row_first_q <= 1'b1;
					end
				end
				ST_SPAN: sp_q <= sp_d;
				ST_ROW: rlast_q <= rlast_d;
				ST_ROWC: begin
					sp_q        <= SP_FIRST;
					row_first_q <= 1'b0;
				end
				ST_CLEAR, ST_SHOW_LD: cnt_q <= cnt_q + (AW+1)'(1);
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (iss_v) begin
			op_cov_q <= iss_cov;
			op_clr_q <= iss_clr;
			op_r_q   <= iss_r;
			op_g_q   <= iss_g;
			op_b_q   <= iss_b;
		end
		// scaled op colour, settled while the slot is placed
		sc_r_q <= scale8(op_r_q, op_cov_q);
		sc_g_q <= scale8(op_g_q, op_cov_q);
		sc_b_q <= scale8(op_b_q, op_cov_q);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					kind_q   <= in_kind;
					col_r_q  <= cmd.in_red;
					col_g_q  <= cmd.in_green;
					col_b_q  <= cmd.in_blue;
					span_x_q <= p0x;
					span_e_q <= p1x;
					span_r_q <= cmd.in_red;
					span_g_q <= cmd.in_green;
					span_b_q <= cmd.in_blue;
					if (in_kind == KIND_RECT) begin
						pa_q <= clamp_pos(p0x, wq);
						pb_q <= clamp_pos(p2x, wq);
					end else begin
						pa_q <= p0x;
						pb_q <= p1x;
					end
					ya_q <= clamp_pos(p1x, hq);
					yb_q <= clamp_pos(p3x, hq);
				end
			end
			ST_SPAN: k_q <= k_d;
			ST_ROW: begin
				row_cov_q <= row_cov_d;
				if (row_first_q) begin
					rk_q   <= {1'b0, y0i};
					base_q <= BW'(y0i * w_eff);
				end else if (!rlast_q) begin
					rk_q   <= rk_q + 8'd1;
					base_q <= base_q + BW'(w_eff);
				end
			end
			ST_ROWC: begin
				span_r_q <= scale8(col_r_q, row_cov_q);
				span_g_q <= scale8(col_g_q, row_cov_q);
				span_b_q <= scale8(col_b_q, row_cov_q);
				span_x_q <= $signed(PW'(base_q) << F) + pa_q;
				span_e_q <= $signed(PW'(base_q) << F) + pb_q;
			end
			ST_SHOW_LD: begin
				pix_idx_q  <= PIX_IDX_W'(cnt_q[AW-1:0]);
				pix_r_q    <= ram_rdata[3*COLOR_W-1:2*COLOR_W];
				pix_g_q    <= ram_rdata[2*COLOR_W-1:COLOR_W];
				pix_b_q    <= ram_rdata[COLOR_W-1:0];
				pix_last_q <= (cnt_q[AW-1:0] == n_last);
			end
			default: ;
		endcase
	end

	assign pix.valid       = pix_v_q;
	assign pix.pixel_index = pix_idx_q;
	assign pix.out_red     = pix_r_q;
	assign pix.out_green   = pix_g_q;
	assign pix.out_blue    = pix_b_q;
	assign pix.last        = pix_last_q;

	alsp_place #(
		.IW(IW),
		.NW(NW),
		.AW(AW)
	) u_place (
		.clk   (clk),
		.arst_n(arst_n),
		.start (iss_v),
		.idx   (iss_idx),
		.n     (n_eff),
		.ring  (ring_q),
		.st    (pl_st),
		.slot  (pl_slot)
	);

	alsp_ram #(
		.WIDTH(FBW),
		.DEPTH(MAX_LEDS)
	) u_fb (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);
endmodule
